// ===== hdl/bes_pkg.sv =====
// Shared types and constants for the byte-order-mark encoding sniffer.
// Used by bes_cfg_regs, bes_detect and the bom_encoding_sniffer top level.
`timescale 1ns / 1ps

package bes_pkg;

  // One input request: a file byte, its presence flag and the start-of-file flag.
  typedef struct packed {
    logic [7:0] byte_value;
    logic       byte_present;
    logic       first_byte;
  } in_t;

  // One result request: the detected encoding and the data offset.
  typedef struct packed {
    logic [3:0]  encoding_code;
    logic [16:0] header_offset;
  } out_t;

  // Configuration registers as seen by the detector.
  typedef struct packed {
    logic [15:0] preset_skip;
    logic [1:0]  encoding_hint;
    logic        petscii_default;
  } cfg_t;

  // Detection phases.
  typedef enum logic [2:0] {
    PH_IDLE,
    PH_SKIP,
    PH_LEAD,
    PH_TAG,
    PH_HDR,
    PH_MARK,
    PH_DONE
  } phase_e;

  // Configuration register indexes.
  localparam logic [1:0] CFG_PRESET_SKIP     = 2'd0;
  localparam logic [1:0] CFG_ENCODING_HINT   = 2'd1;
  localparam logic [1:0] CFG_PETSCII_DEFAULT = 2'd2;

  localparam int unsigned CFG_DATA_W = 16;

  // Caller encoding hints.
  localparam logic [1:0] HINT_ABSENT  = 2'd0;
  localparam logic [1:0] HINT_UNKNOWN = 2'd1;
  localparam logic [1:0] HINT_DEFAULT = 2'd2;
  localparam logic [1:0] HINT_KNOWN   = 2'd3;

  // Encoding codes reported in a result.
  localparam logic [3:0] CODE_UTF32BE  = 4'd0;
  localparam logic [3:0] CODE_PETSCII  = 4'd1;
  localparam logic [3:0] CODE_UTF8     = 4'd2;
  localparam logic [3:0] CODE_UTF16BE  = 4'd3;
  localparam logic [3:0] CODE_UTF32LE  = 4'd4;
  localparam logic [3:0] CODE_UTF16LE  = 4'd5;
  localparam logic [3:0] CODE_EBCDIC   = 4'd6;
  localparam logic [3:0] CODE_FALLBACK = 4'd7;
  localparam logic [3:0] CODE_KEPT     = 4'd8;

  // Mark byte values.
  localparam logic [7:0] BYTE_ZERO    = 8'h00;
  localparam logic [7:0] BYTE_PET_LO  = 8'h01;
  localparam logic [7:0] BYTE_PET_HI  = 8'h08;
  localparam logic [7:0] BYTE_UTF8_0  = 8'hEF;
  localparam logic [7:0] BYTE_UTF8_1  = 8'hBB;
  localparam logic [7:0] BYTE_UTF8_2  = 8'hBF;
  localparam logic [7:0] BYTE_FE      = 8'hFE;
  localparam logic [7:0] BYTE_FF      = 8'hFF;
  localparam logic [7:0] EBC_E_LOWER  = 8'd133;
  localparam logic [7:0] EBC_E_UPPER  = 8'd197;
  localparam logic [7:0] EBC_N_LOWER  = 8'd149;
  localparam logic [7:0] EBC_N_UPPER  = 8'd213;
  localparam logic [7:0] EBC_C_LOWER  = 8'd131;
  localparam logic [7:0] EBC_C_UPPER  = 8'd195;

  // Disk header tag "PLUS3DOS" and the length of the header it announces.
  localparam logic [7:0] TAG_TEXT [8] = '{8'd80, 8'd76, 8'd85, 8'd83,
                                          8'd51, 8'd68, 8'd79, 8'd83};
  localparam int unsigned TAG_LEN = 8;
  localparam int unsigned HDR_LEN = 128;

  // Offset forced when the petscii_default register selects PETSCII.
  localparam logic [16:0] PETSCII_OFFSET = 17'd2;

endpackage

// ===== hdl/bes_cfg_regs.sv =====
// Configuration register file for the encoding sniffer.
// Depends on bes_pkg for the register indexes and the cfg_t struct.
`timescale 1ns / 1ps

module bes_cfg_regs (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [1:0]                   cfg_idx_i,
  input  logic [bes_pkg::CFG_DATA_W-1:0] cfg_wdata_i,
  output bes_pkg::cfg_t                cfg_o
);
  import bes_pkg::*;

  cfg_t cfg_q;

  // Write decode; an index past the last register is dropped.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.preset_skip     <= 16'd0;
      cfg_q.encoding_hint   <= HINT_UNKNOWN;
      cfg_q.petscii_default <= 1'b0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_PRESET_SKIP:     cfg_q.preset_skip     <= cfg_wdata_i[15:0];
        CFG_ENCODING_HINT:   cfg_q.encoding_hint   <= cfg_wdata_i[1:0];
        CFG_PETSCII_DEFAULT: cfg_q.petscii_default <= cfg_wdata_i[0];
        default: ;
      endcase
    end
  end

  assign cfg_o = cfg_q;

endmodule

// ===== hdl/bes_detect.sv =====
// Detection state and per-byte decision logic of the encoding sniffer.
// Depends on bes_pkg for the phase enum, mark constants and payload structs.
`timescale 1ns / 1ps

module bes_detect #(
  parameter int unsigned OFFSET_BITS = 16
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          en_i,
  input  bes_pkg::in_t  item_i,
  input  bes_pkg::cfg_t cfg_i,
  output logic          res_valid_o,
  output bes_pkg::out_t res_o
);
  import bes_pkg::*;

  // Only the low OFFSET_BITS bits (at most 16) of the 16-bit skip register take part.
  localparam int unsigned SKIP_W = (OFFSET_BITS < 16) ? OFFSET_BITS : 16;
  localparam int unsigned POS_W  = SKIP_W;

  phase_e           phase_q, phase_d;
  logic [POS_W-1:0] pos_q, pos_d;
  logic [7:0]       lead_q, lead_d;
  logic             hdr_q, hdr_d;

  // Effective state once a first byte has restarted detection.
  phase_e           ph;
  logic [POS_W-1:0] pos;
  logic [7:0]       lead;
  logic             hdr;

  logic [SKIP_W-1:0] skip;
  logic              skip_zero;
  logic [POS_W:0]    pos_inc;
  logic              hint_unknown;
  logic              pres;
  logic [7:0]        bval;

  // Decision outputs of this byte.
  logic        fin;
  logic        mark_hit;
  logic [3:0]  mark_code;
  logic [2:0]  mark_add;
  logic [16:0] base_off;
  logic [16:0] off;
  logic [3:0]  enc;

  assign skip         = cfg_i.preset_skip[SKIP_W-1:0];
  assign skip_zero    = (skip == '0);
  assign hint_unknown = (cfg_i.encoding_hint == HINT_UNKNOWN);
  assign pres         = item_i.byte_present;
  assign bval         = item_i.byte_value;

  assign ph   = item_i.first_byte ? (skip_zero ? PH_LEAD : PH_SKIP) : phase_q;
  assign pos  = item_i.first_byte ? '0 : pos_q;
  assign lead = item_i.first_byte ? 8'd0 : lead_q;
  assign hdr  = item_i.first_byte ? 1'b0 : hdr_q;

  assign pos_inc = {1'b0, pos} + {{POS_W{1'b0}}, 1'b1};

  // Phase walk: skip, tag, header jump, lead byte and mark tail.
  always_comb begin
    phase_d   = ph;
    pos_d     = pos;
    lead_d    = lead;
    hdr_d     = hdr;
    fin       = 1'b0;
    mark_hit  = 1'b0;
    mark_code = CODE_KEPT;
    mark_add  = 3'd0;
    case (ph)
      PH_SKIP: begin
        if (!pres) begin
          fin = 1'b1;
        end else begin
          pos_d = pos_inc[POS_W-1:0];
          if (pos_inc >= {1'b0, skip}) begin
            phase_d = PH_LEAD;
          end
        end
      end
      PH_LEAD: begin
        if (!hdr && skip_zero && hint_unknown && pres && bval == TAG_TEXT[0]) begin
          phase_d = PH_TAG;
          pos_d   = POS_W'(1);
        end else if (pres && (bval == BYTE_ZERO || bval == BYTE_PET_LO ||
                              bval == BYTE_UTF8_0 || bval == BYTE_FE ||
                              bval == BYTE_FF ||
                              ((bval == EBC_E_LOWER || bval == EBC_E_UPPER) &&
                               hint_unknown))) begin
          lead_d  = bval;
          phase_d = PH_MARK;
          pos_d   = POS_W'(1);
        end else begin
          fin = 1'b1;
        end
      end
      PH_TAG: begin
        if (pres && bval == TAG_TEXT[pos[2:0]]) begin
          pos_d = pos_inc[POS_W-1:0];
          if (pos_inc == (POS_W+1)'(TAG_LEN)) begin
            hdr_d   = 1'b1;
            phase_d = PH_HDR;
          end
        end else begin
          fin = 1'b1;
        end
      end
      PH_HDR: begin
        if (!pres) begin
          fin = 1'b1;
        end else begin
          pos_d = pos_inc[POS_W-1:0];
          if (pos_inc >= (POS_W+1)'(HDR_LEN)) begin
            phase_d = PH_LEAD;
          end
        end
      end
      PH_MARK: begin
        pos_d = pos_inc[POS_W-1:0];
        case (lead)
          BYTE_ZERO: begin
            // UTF-32BE: 00 00 FE FF
            if (pos == POS_W'(1)) begin
              fin = !(pres && bval == BYTE_ZERO);
            end else if (pos == POS_W'(2)) begin
              fin = !(pres && bval == BYTE_FE);
            end else begin
              fin = 1'b1;
              if (pres && bval == BYTE_FF) begin
                mark_hit  = 1'b1;
                mark_code = CODE_UTF32BE;
                mark_add  = 3'd4;
              end
            end
          end
          BYTE_PET_LO: begin
            // PETSCII load address 01 08
            fin = 1'b1;
            if (pres && bval == BYTE_PET_HI) begin
              mark_hit  = 1'b1;
              mark_code = CODE_PETSCII;
              mark_add  = 3'd2;
            end
          end
          BYTE_UTF8_0: begin
            // UTF-8: EF BB BF
            if (pos == POS_W'(1)) begin
              fin = !(pres && bval == BYTE_UTF8_1);
            end else begin
              fin = 1'b1;
              if (pres && bval == BYTE_UTF8_2) begin
                mark_hit  = 1'b1;
                mark_code = CODE_UTF8;
                mark_add  = 3'd3;
              end
            end
          end
          BYTE_FE: begin
            // UTF-16BE: FE FF
            fin = 1'b1;
            if (pres && bval == BYTE_FF) begin
              mark_hit  = 1'b1;
              mark_code = CODE_UTF16BE;
              mark_add  = 3'd2;
            end
          end
          BYTE_FF: begin
            // FF FE is UTF-16LE unless two zero bytes follow (UTF-32LE).
            if (pos == POS_W'(1)) begin
              fin = !(pres && bval == BYTE_FE);
            end else if (pos == POS_W'(2)) begin
              if (!(pres && bval == BYTE_ZERO)) begin
                fin       = 1'b1;
                mark_hit  = 1'b1;
                mark_code = CODE_UTF16LE;
                mark_add  = 3'd2;
              end
            end else begin
              fin      = 1'b1;
              mark_hit = 1'b1;
              if (pres && bval == BYTE_ZERO) begin
                mark_code = CODE_UTF32LE;
                mark_add  = 3'd4;
              end else begin
                mark_code = CODE_UTF16LE;
                mark_add  = 3'd2;
              end
            end
          end
          default: begin
            // EBCDIC letters "enc" in either case.
            if (pos == POS_W'(1)) begin
              fin = !(pres && (bval == EBC_N_LOWER || bval == EBC_N_UPPER));
            end else begin
              fin = 1'b1;
              if (pres && (bval == EBC_C_LOWER || bval == EBC_C_UPPER)) begin
                mark_hit  = 1'b1;
                mark_code = CODE_EBCDIC;
                mark_add  = 3'd0;
              end
            end
          end
        endcase
      end
      default: ;
    endcase
    if (fin) begin
      phase_d = PH_DONE;
    end
  end

  // Result code and offset once the decision is made.
  assign base_off = hdr ? 17'(HDR_LEN) : 17'(skip);

  always_comb begin
    off = base_off + {14'd0, mark_add};
    if (cfg_i.encoding_hint == HINT_ABSENT) begin
      enc = CODE_KEPT;
    end else if (mark_hit) begin
      enc = mark_code;
    end else if (cfg_i.encoding_hint == HINT_UNKNOWN ||
                 cfg_i.encoding_hint == HINT_DEFAULT) begin
      enc = CODE_FALLBACK;
      if (cfg_i.petscii_default) begin
        off = PETSCII_OFFSET;
      end
    end else begin
      enc = CODE_KEPT;
    end
  end

  assign res_valid_o         = en_i && fin;
  assign res_o.encoding_code = enc;
  assign res_o.header_offset = off;

  // State registers advance only for a processed byte.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_IDLE;
      pos_q   <= '0;
      lead_q  <= 8'd0;
      hdr_q   <= 1'b0;
    end else if (en_i) begin
      phase_q <= phase_d;
      pos_q   <= pos_d;
      lead_q  <= lead_d;
      hdr_q   <= hdr_d;
    end
  end

endmodule

// ===== hdl/bom_encoding_sniffer.sv =====
// Top level of the byte-order-mark encoding sniffer: request registers and handshake.
// Depends on bes_pkg, bes_cfg_regs and bes_detect.
//
// Usage: file bytes enter on the input channel (in_valid_i / in_stall_o), one
// request per byte, with first_byte set on byte 0 of each file and
// byte_present cleared to signal end of file. For each file at most one
// result request leaves on the output channel (out_valid_o / out_stall_i)
// with the encoding code and the offset where text data begins.
// Each byte is held in an input register, decided by one level of compare
// logic in the detector and written to an output register, so a byte is
// accepted every cycle while in_stall_o is low.
// While the receiver stalls, a finished result stays in the output register;
// one more byte is taken into the input register and then in_stall_o rises
// until the result is taken.
// Reset empties both registers, returns detection to idle (bytes before a
// first byte are dropped) and loads the registers with preset_skip 0,
// encoding_hint unknown and petscii_default 0. Configuration is written
// through cfg_we_i / cfg_idx_i / cfg_wdata_i while no byte is in flight.
`timescale 1ns / 1ps

module bom_encoding_sniffer #(
  parameter int unsigned OFFSET_BITS = 16
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [1:0]                     cfg_idx_i,
  input  logic [bes_pkg::CFG_DATA_W-1:0] cfg_wdata_i,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  bes_pkg::in_t                   in_data_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output bes_pkg::out_t                  out_data_o
);
  import bes_pkg::*;

  cfg_t cfg;

  logic in_valid_q;
  in_t  in_q;
  logic out_valid_q;
  out_t out_q;

  logic proc;
  logic accept;
  logic res_valid;
  out_t res;

  // Configuration registers.
  bes_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  // The held byte is processed whenever the output register can take a result.
  assign proc       = in_valid_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o = in_valid_q && !proc;
  assign accept     = in_valid_i && !in_stall_o;

  // Detection state and decision logic.
  bes_detect #(
    .OFFSET_BITS (OFFSET_BITS)
  ) u_detect (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .en_i        (proc),
    .item_i      (in_q),
    .cfg_i       (cfg),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  // Input request register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (accept) begin
      in_valid_q <= 1'b1;
    end else if (proc) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      in_q <= in_data_i;
    end
  end

  // Output request register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (proc && res_valid) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (proc && res_valid) begin
      out_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // A stall is only raised while a byte waits in the input register.
  a_stall_has_byte : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> in_valid_q)
    else $error("input stalled with an empty input register");

  // A byte is never decided into an occupied, stalled output register.
  a_no_overwrite : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(proc && res_valid && out_valid_q && out_stall_i))
    else $error("result overwrote a stalled result");

  // Reported codes stay within the defined encodings.
  a_code_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_data_o.encoding_code <= CODE_KEPT))
    else $error("encoding code out of range");

  // A newly registered result follows a cycle in which a byte sat in the input register.
  a_result_follows_byte : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !$past(out_valid_o)) |-> $past(in_valid_q))
    else $error("result without a processed byte");

endmodule
